// File: rtl/voxel_chunk_store_access_top_defines.svh
// ----------------------------------------------------------------------------
// Voxel chunk store access: assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef VOXEL_CHUNK_STORE_ACCESS_TOP_DEFINES_SVH
`define VOXEL_CHUNK_STORE_ACCESS_TOP_DEFINES_SVH

// Same-cycle implication.
`define VCSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel chunk store: same-cycle check failed");

// Next-cycle implication.
`define VCSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel chunk store: next-cycle check failed");

`endif

// File: rtl/vcsa_pkg.sv
// ----------------------------------------------------------------------------
// Voxel chunk store access package
// Geometry constants, beat types and the per-axis coordinate split.
// ----------------------------------------------------------------------------
package vcsa_pkg;

  localparam int CHUNK_EDGE  = 16;
  localparam int SLOT_COUNT  = 27;
  localparam int SLOT_ROW    = 3;
  localparam int SLOT_PLANE  = 9;
  localparam int CHUNK_AREA  = CHUNK_EDGE * CHUNK_EDGE;
  localparam int CHUNK_VOL   = CHUNK_AREA * CHUNK_EDGE;
  localparam int STORE_DEPTH = SLOT_COUNT * CHUNK_VOL;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LOC_W       = $clog2(CHUNK_EDGE);
  localparam int SLOT_W      = 5;
  localparam int VOXEL_W     = 16;
  localparam int COORD_W     = 16;
  localparam int CFG_W       = 27;

  typedef enum logic [0:0] {
    CFG_READY_MASK = 1'b0,
    CFG_PIPE_IDLE  = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [VOXEL_W-1:0]        write_value;
  } req_t;

  typedef struct packed {
    logic [VOXEL_W-1:0]    read_value;
    logic                  hit;
    logic [SLOT_W-1:0]     slot_index;
    logic [SLOT_COUNT-1:0] changed_mask;
  } rsp_t;

  // Decoded request handed from the address unit to the access stage.
  typedef struct packed {
    logic               served;
    logic               is_write;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  addr;
    logic [VOXEL_W-1:0] wdata;
  } dec_t;

  typedef struct packed {
    logic             in_range;
    logic [1:0]       offset;
    logic [LOC_W-1:0] local_pos;
  } axis_t;

  // Floor split against one chunk edge. Only offsets -1..1 matter, so the
  // coordinate must fall in [-E, 2E-1]; four compares pick the band.
  function automatic axis_t split_axis(logic signed [COORD_W-1:0] c);
    logic signed [COORD_W:0] cw;
    logic signed [COORD_W:0] e;
    logic signed [COORD_W:0] sum;
    axis_t a;
    cw = {c[COORD_W-1], c};
    e  = (COORD_W+1)'(CHUNK_EDGE);
    a.in_range = 1'b1;
    if (cw < -e) begin
      a.in_range = 1'b0;
      a.offset   = 2'd0;
      sum        = cw;
    end else if (cw < 0) begin
      a.offset = 2'd0;
      sum      = cw + e;
    end else if (cw < e) begin
      a.offset = 2'd1;
      sum      = cw;
    end else if (cw < (e <<< 1)) begin
      a.offset = 2'd2;
      sum      = cw - e;
    end else begin
      a.in_range = 1'b0;
      a.offset   = 2'd0;
      sum        = cw;
    end
    a.local_pos = sum[LOC_W-1:0];
    return a;
  endfunction

endpackage

// File: rtl/vcsa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or registered read; read data holds otherwise.
// ----------------------------------------------------------------------------
module vcsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/vcsa_decode.sv
// ----------------------------------------------------------------------------
// Voxel chunk store address unit
// Split coordinates, form slot and store address, decide whether to serve.
// ----------------------------------------------------------------------------
module vcsa_decode (
  input  vcsa_pkg::req_t                    req,
  input  logic [vcsa_pkg::SLOT_COUNT-1:0]   ready_mask,
  input  logic                              pipe_idle,
  output vcsa_pkg::dec_t                    dec
);

  vcsa_pkg::axis_t ax;
  vcsa_pkg::axis_t ay;
  vcsa_pkg::axis_t az;
  logic            in_range;
  logic [vcsa_pkg::SLOT_W-1:0] slot;
  logic [vcsa_pkg::ADDR_W-1:0] addr;
  logic            is_write;

  assign ax = vcsa_pkg::split_axis(req.coord_x);
  assign ay = vcsa_pkg::split_axis(req.coord_y);
  assign az = vcsa_pkg::split_axis(req.coord_z);

  assign in_range = ax.in_range && ay.in_range && az.in_range;
  assign is_write = (req.opcode == vcsa_pkg::OP_WRITE);

  always_comb begin
    slot = '0;
    if (in_range) begin
      slot = vcsa_pkg::SLOT_W'(az.offset) * vcsa_pkg::SLOT_W'(vcsa_pkg::SLOT_PLANE)
           + vcsa_pkg::SLOT_W'(ay.offset) * vcsa_pkg::SLOT_W'(vcsa_pkg::SLOT_ROW)
           + vcsa_pkg::SLOT_W'(ax.offset);
    end
  end

  assign addr = vcsa_pkg::ADDR_W'(slot) * vcsa_pkg::ADDR_W'(vcsa_pkg::CHUNK_VOL)
              + vcsa_pkg::ADDR_W'(az.local_pos) * vcsa_pkg::ADDR_W'(vcsa_pkg::CHUNK_AREA)
              + vcsa_pkg::ADDR_W'(ay.local_pos) * vcsa_pkg::ADDR_W'(vcsa_pkg::CHUNK_EDGE)
              + vcsa_pkg::ADDR_W'(ax.local_pos);

  // Idle gates reads only; writes go through whenever in range and the chunk is ready.
  assign dec.served   = in_range && ready_mask[slot] && (is_write || pipe_idle);
  assign dec.is_write = is_write;
  assign dec.slot     = slot;
  assign dec.addr     = addr;
  assign dec.wdata    = req.write_value;

endmodule

// File: rtl/voxel_chunk_store_access_top.sv
// ----------------------------------------------------------------------------
// Voxel chunk store access, top level
// Reads or writes one voxel in a 3x3x3 neighborhood of cubic chunks.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid / in_stall      in_data  (vcsa_pkg::req_t)
//   out      source     out_valid / out_stall    out_data (vcsa_pkg::rsp_t)
//   cfg      sink       cfg_we                   cfg_index, cfg_data
//
// One beat per cycle sustained while not stalled; each beat passes the request
// register, the RAM's registered read port and the output register on its way
// from input to output.
// Reset clears the pipeline valids, the changed flags and both config
// registers; the voxel store itself is not cleared and needs no sweep.
// out_stall, while the output register holds a beat, freezes every stage together and is passed back as in_stall.
// ----------------------------------------------------------------------------
`include "voxel_chunk_store_access_top_defines.svh"

module voxel_chunk_store_access_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  vcsa_pkg::cfg_index_t           cfg_index,
  input  logic [vcsa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vcsa_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vcsa_pkg::rsp_t                 out_data
);

  // Configuration registers.
  logic [vcsa_pkg::SLOT_COUNT-1:0] ready_mask;
  logic                            pipe_idle;

  // Decode stage: raw request beat.
  logic           d_v;
  vcsa_pkg::req_t d_req;
  vcsa_pkg::dec_t dec;

  // Access stage: RAM access in flight, metadata alongside.
  logic                            m_v;
  logic                            m_hit;
  logic                            m_read;
  logic [vcsa_pkg::SLOT_W-1:0]     m_slot;
  logic [vcsa_pkg::SLOT_COUNT-1:0] m_changed;

  // Output register.
  logic           o_v;
  vcsa_pkg::rsp_t o_rsp;

  logic [vcsa_pkg::SLOT_COUNT-1:0] changed;
  logic [vcsa_pkg::SLOT_COUNT-1:0] changed_next;
  logic [vcsa_pkg::VOXEL_W-1:0]    ram_rdata;
  logic                            ram_en;
  logic                            adv;

  // Advance the whole pipe whenever the output slot is free or drains.
  assign adv      = !o_v || !out_stall;
  assign in_stall = !adv;

  // Config writes: the user must keep the block idle whenever they arrive; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask <= '0;
      pipe_idle  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcsa_pkg::CFG_READY_MASK: ready_mask <= cfg_data[vcsa_pkg::SLOT_COUNT-1:0];
        vcsa_pkg::CFG_PIPE_IDLE:  pipe_idle  <= cfg_data[0];
      endcase
    end
  end

  vcsa_decode u_decode (
    .req        (d_req),
    .ready_mask (ready_mask),
    .pipe_idle  (pipe_idle),
    .dec        (dec)
  );

  // Issue the store access as the beat leaves the decode stage.
  assign ram_en = adv && d_v && dec.served;

  vcsa_ram #(
    .WIDTH (vcsa_pkg::VOXEL_W),
    .DEPTH (vcsa_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (dec.is_write),
    .addr  (dec.addr),
    .wdata (dec.wdata),
    .rdata (ram_rdata)
  );

  // Mark the chunk of every served write; flags only ever accumulate.
  always_comb begin
    changed_next = changed;
    if (d_v && dec.served && dec.is_write) begin
      changed_next = changed | (vcsa_pkg::SLOT_COUNT'(1) << dec.slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v     <= 1'b0;
      m_v     <= 1'b0;
      o_v     <= 1'b0;
      changed <= '0;
    end else if (adv) begin
      d_v     <= in_valid;
      m_v     <= d_v;
      o_v     <= m_v;
      changed <= changed_next;
    end
  end

  // Payload registers: no reset, hold while stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_req     <= in_data;
      m_hit     <= dec.served;
      m_read    <= dec.served && !dec.is_write;
      m_slot    <= dec.slot;
      m_changed <= changed_next;
      o_rsp.read_value   <= m_read ? ram_rdata : '0;
      o_rsp.hit          <= m_hit;
      o_rsp.slot_index   <= m_slot;
      o_rsp.changed_mask <= m_changed;
    end
  end

  assign out_valid = o_v;
  assign out_data  = o_rsp;

  // Changed flags never drop outside reset.
  `VCSA_ASSERT_NEXT(a_changed_sticky, 1'b1, (changed & $past(changed)) == $past(changed))
  // A frozen pipe must keep the read data of the access in flight.
  `VCSA_ASSERT_NEXT(a_rdata_held, o_v && out_stall && m_v && m_read, $stable(ram_rdata))
  // A hit always points at a ready chunk slot.
  `VCSA_ASSERT_NOW(a_hit_ready, o_v && o_rsp.hit, ((ready_mask >> o_rsp.slot_index) & 27'd1) != 27'd0)
  // A served write leaves its chunk marked in the reported flags.
  `VCSA_ASSERT_NOW(a_write_marks, m_v && m_hit && !m_read, ((m_changed >> m_slot) & 27'd1) != 27'd0)

endmodule
